[rtl/hdr_tonemap_srgb_encode_macros.svh]
// assertion macros for the hdr tone map and srgb encode block
`ifndef HDR_TONEMAP_SRGB_ENCODE_MACROS_SVH
`define HDR_TONEMAP_SRGB_ENCODE_MACROS_SVH

// same-cycle implication, checked out of reset
`define HTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication that is also checked while reset is applied
`define HTS_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/hts_pkg.sv]
// shared types, constants and power tables for the hdr tone map block
`default_nettype none

package hts_pkg;

  // code and table sizing
  localparam int CODE_BITS             = 16;
  localparam int POWER_TABLE_ADDR_BITS = 8;

  localparam int FRAC       = 24;
  localparam int SEG_SHIFT  = FRAC - POWER_TABLE_ADDR_BITS;
  localparam int TABLE_SIZE = (1 << POWER_TABLE_ADDR_BITS) + 1;
  localparam int TIDX_W     = POWER_TABLE_ADDR_BITS + 1;
  localparam int ROOT_W     = 25;
  localparam int OCT_N      = 10;
  localparam int OCT_IDX_W  = 4;

  // fixed-point constants of the curve and the srgb encode
  localparam logic [23:0] LIN_LIMIT  = 24'd52527;
  localparam logic [19:0] LIN_SLOPE  = 20'd846725;
  localparam logic [24:0] ENC_GAIN   = 25'd17699963;
  localparam logic [27:0] ENC_OFFSET = 28'd922747;
  localparam logic [CODE_BITS-1:0] MAX_CODE = {CODE_BITS{1'b1}};
  localparam logic [63:0] UNIT64     = 64'd1 << FRAC;

  // register map and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE    = 2'd1;
  localparam logic [23:0] ONE_Q816 = 24'h010000;

  // pipeline geometry
  localparam int DIV_STEPS = 24;
  localparam int REM_W     = 34;
  localparam int E_DL      = 25;
  localparam int SAT_DL    = 53;
  localparam int LAT       = 55;
  localparam int Y_W       = 29;

  typedef struct packed {
    logic signed [23:0] red_radiance;
    logic signed [23:0] green_radiance;
    logic signed [23:0] blue_radiance;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] red_code;
    logic [15:0] green_code;
    logic [15:0] blue_code;
  } pix_out_t;

  typedef struct packed {
    logic [23:0] gain;
    logic [23:0] white;
  } hts_cfg_t;

  typedef logic [ROOT_W-1:0] root_tab_t [TABLE_SIZE];
  typedef logic [ROOT_W-1:0] oct_tab_t [OCT_N];

  // twelfth power with truncation after every product
  function automatic logic [63:0] pow12_f(input logic [63:0] v);
    logic [63:0] v2, v4, v8;
    v2 = (v * v) >> FRAC;
    v4 = (v2 * v2) >> FRAC;
    v8 = (v4 * v4) >> FRAC;
    return (v8 * v4) >> FRAC;
  endfunction

  // largest q.24 value in [1,2) whose twelfth power stays at or below target
  function automatic logic [63:0] root12_f(input logic [63:0] target);
    logic [63:0] lo, hi, mid;
    lo = UNIT64;
    hi = UNIT64 << 1;
    for (int i = 0; i < FRAC; i++) begin
      mid = (lo + hi) >> 1;
      if (pow12_f(mid) <= target) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // m^(5/12) at evenly spaced mantissa points
  function automatic root_tab_t build_root_tab();
    root_tab_t tab;
    logic [63:0] m, m2, m4, m5;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      m  = UNIT64 + (64'(i) << SEG_SHIFT);
      m2 = (m * m) >> FRAC;
      m4 = (m2 * m2) >> FRAC;
      m5 = (m4 * m) >> FRAC;
      tab[i] = ROOT_W'(root12_f(m5));
    end
    return tab;
  endfunction

  // 2^(-5e/12) per octave
  function automatic oct_tab_t build_oct_tab();
    oct_tab_t tab;
    int k, s;
    logic [63:0] v;
    tab[0] = ROOT_W'(UNIT64);
    for (int i = 1; i < OCT_N; i++) begin
      k = (5 * i + 11) / 12;
      s = 12 * k - 5 * i;
      v = root12_f(UNIT64 << s);
      tab[i] = ROOT_W'((v + (64'd1 << (k - 1))) >> k);
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_root_tab();
  localparam oct_tab_t  OCT_TAB  = build_oct_tab();

endpackage

`default_nettype wire

[rtl/hts_div.sv]
// pipelined restoring divider, one quotient bit per stage, fractional quotient
`default_nettype none

module hts_div import hts_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [REM_W-1:0]     rem_in,
  input  logic [REM_W-1:0]     dvsr_in,
  output logic [DIV_STEPS-1:0] quo
);

  logic [REM_W-1:0]     rem_r  [DIV_STEPS-1];
  logic [REM_W-1:0]     dvsr_r [DIV_STEPS-1];
  logic [DIV_STEPS-1:0] quo_r  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [REM_W-1:0]     rem_prev;
    logic [REM_W-1:0]     dvsr_prev;
    logic [DIV_STEPS-1:0] quo_prev;
    logic [REM_W:0]       dbl;
    logic                 fits;

    // operands from the previous stage
    if (j == 0) begin : g_first
      assign rem_prev  = rem_in;
      assign dvsr_prev = dvsr_in;
      assign quo_prev  = '0;
    end else begin : g_next
      assign rem_prev  = rem_r[j-1];
      assign dvsr_prev = dvsr_r[j-1];
      assign quo_prev  = quo_r[j-1];
    end

    // shift the partial remainder and try a subtract
    assign dbl  = {rem_prev, 1'b0};
    assign fits = dbl >= {1'b0, dvsr_prev};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j] <= {quo_prev[DIV_STEPS-2:0], fits};
      end
    end

    if (j < DIV_STEPS - 1) begin : g_carry
      logic [REM_W-1:0] rem_nxt;
      assign rem_nxt = fits ? REM_W'(dbl - {1'b0, dvsr_prev}) : REM_W'(dbl);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j]  <= rem_nxt;
          dvsr_r[j] <= dvsr_prev;
        end
      end
    end
  end

  assign quo = quo_r[DIV_STEPS-1];

endmodule

`default_nettype wire

[rtl/hts_chan.sv]
// one color channel: exposure, reinhard curve, srgb encode
`default_nettype none

module hts_chan import hts_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  hts_cfg_t           cfg,
  input  logic signed [23:0] radiance,
  output logic [15:0]        code
);

  // exposure: clamp negatives, scale, saturate
  logic [22:0] rad_pos;
  logic [46:0] e_prod;
  logic [23:0] e_nxt;
  logic [23:0] e_r;

  assign rad_pos = radiance[23] ? '0 : radiance[22:0];
  assign e_prod  = rad_pos * cfg.gain;
  assign e_nxt   = (|e_prod[46:40]) ? 24'hFFFFFF : e_prod[39:16];

  always_ff @(posedge clk) begin
    if (en) e_r <= e_nxt;
  end

  // white point reached: full code
  logic sat_nxt;
  assign sat_nxt = e_r >= cfg.white;

  logic        sat_dl_r [SAT_DL];
  logic [23:0] e_dl_r   [E_DL];

  always_ff @(posedge clk) begin
    if (en) begin
      sat_dl_r[0] <= sat_nxt;
      e_dl_r[0]   <= e_r;
      for (int k = 1; k < SAT_DL; k++) sat_dl_r[k] <= sat_dl_r[k-1];
      for (int k = 1; k < E_DL; k++) e_dl_r[k] <= e_dl_r[k-1];
    end
  end

  // g = e / w
  logic [23:0] g;

  hts_div u_gdiv (
    .clk     (clk),
    .en      (en),
    .rem_in  (REM_W'(e_r)),
    .dvsr_in (REM_W'(cfg.white)),
    .quo     (g)
  );

  logic [47:0] gg_r;

  always_ff @(posedge clk) begin
    if (en) gg_r <= g * g;
  end

  // t = (e + g^2) / (1 + e), scaled by 2^8 for e
  logic [32:0] num;
  logic [32:0] den;
  logic [23:0] t;

  assign num = 33'({e_dl_r[E_DL-1], 8'h00}) + 33'(gg_r[47:24]);
  assign den = 33'({e_dl_r[E_DL-1], 8'h00}) + 33'(UNIT64);

  hts_div u_tdiv (
    .clk     (clk),
    .en      (en),
    .rem_in  (REM_W'(num)),
    .dvsr_in (REM_W'(den)),
    .quo     (t)
  );

  // normalize t into a mantissa and look up the root table
  logic                    lin_nxt;
  logic [43:0]             linp_nxt;
  logic [OCT_IDX_W-1:0]    sh;
  logic [32:0]             shifted;
  logic [23:0]             frac;
  logic [TIDX_W-1:0]       tidx;
  logic [TIDX_W-1:0]       tidx_p1;
  logic [SEG_SHIFT-1:0]    seg_rem;
  logic [ROOT_W-1:0]       tab_a;
  logic [ROOT_W-1:0]       tab_b;

  assign lin_nxt  = t < LIN_LIMIT;
  assign linp_nxt = t * LIN_SLOPE;

  always_comb begin
    sh = OCT_IDX_W'(9);
    for (int k = 9; k >= 1; k--) begin
      if ((t >> (24 - k)) != '0) sh = OCT_IDX_W'(k);
    end
  end

  assign shifted = {9'h000, t} << sh;
  assign frac    = shifted[23:0];
  assign tidx    = {1'b0, frac[23:SEG_SHIFT]};
  assign tidx_p1 = tidx + 1'b1;
  assign seg_rem = frac[SEG_SHIFT-1:0];
  assign tab_a   = ROOT_TAB[tidx];
  assign tab_b   = ROOT_TAB[tidx_p1];

  logic [ROOT_W-1:0]    a1_r, d1_r, a2_r;
  logic [SEG_SHIFT-1:0] rem1_r;
  logic [OCT_IDX_W-1:0] sh1_r, sh2_r;
  logic                 lin1_r, lin2_r, lin3_r, lin4_r;
  logic [43:0]          linp1_r, linp2_r, linp3_r, linp4_r;
  logic [ROOT_W+SEG_SHIFT-1:0] dprod2_r;
  logic [2*ROOT_W-1:0]  pfull3_r;
  logic [50:0]          qprod4_r;

  // interpolation and octave scaling
  logic [ROOT_W-1:0] ym;
  logic [25:0]       p;

  assign ym = a2_r + ROOT_W'(dprod2_r >> SEG_SHIFT);
  assign p  = pfull3_r[49:24];

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r     <= tab_a;
      d1_r     <= tab_b - tab_a;
      rem1_r   <= seg_rem;
      sh1_r    <= sh;
      lin1_r   <= lin_nxt;
      linp1_r  <= linp_nxt;
      dprod2_r <= d1_r * rem1_r;
      a2_r     <= a1_r;
      sh2_r    <= sh1_r;
      lin2_r   <= lin1_r;
      linp2_r  <= linp1_r;
      pfull3_r <= ym * OCT_TAB[sh2_r];
      lin3_r   <= lin2_r;
      linp3_r  <= linp2_r;
      qprod4_r <= p * ENC_GAIN;
      lin4_r   <= lin3_r;
      linp4_r  <= linp3_r;
    end
  end

  // srgb offset, linear segment select, rounding to the code width
  logic [51:0]          q_sum;
  logic [27:0]          q;
  logic [44:0]          lin_sum;
  logic [Y_W-1:0]       y;
  logic [Y_W:0]         code_full;
  logic [CODE_BITS-1:0] code_nxt;
  logic [CODE_BITS-1:0] code_r;

  assign q_sum   = 52'(qprod4_r) + 52'(1 << 23);
  assign q       = q_sum[51:24];
  assign lin_sum = 45'(linp4_r) + 45'(32768);

  always_comb begin
    if (lin4_r) y = Y_W'(lin_sum[44:16]);
    else if (q > ENC_OFFSET) y = Y_W'(q - ENC_OFFSET);
    else y = '0;
    code_full = ((Y_W+1)'(y) + (Y_W+1)'(1 << (23 - CODE_BITS))) >> (24 - CODE_BITS);
    if (sat_dl_r[SAT_DL-1]) code_nxt = MAX_CODE;
    else if (code_full > (Y_W+1)'(MAX_CODE)) code_nxt = MAX_CODE;
    else code_nxt = code_full[CODE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) code_r <= code_nxt;
  end

  assign code = 16'(code_r);

endmodule

`default_nettype wire

[rtl/hdr_tonemap_srgb_encode.sv]
// top level: config registers, pipeline valid tracking, three channel datapaths
//
// HDR tone mapper with sRGB encoding. Each pixel carries three signed Q8.16
// radiance channels; each is clamped at zero, scaled by exposure_gain, passed
// through the extended Reinhard curve against white_point, and sRGB encoded
// to an unsigned code (all-ones at or above white). A pixel is accepted on
// every cycle the output side is not stalled; the pipeline depth is set by
// the two 24-stage radix-2 dividers per channel (e/w and the Reinhard
// quotient) plus the multiply stages around them. A stalled result holds
// the whole pipeline. Configuration is written through cfg_we/cfg_index/
// cfg_wdata and must only change with no pixel in flight; a white point of
// zero is taken as 1.0.
`default_nettype none

`include "hdr_tonemap_srgb_encode_macros.svh"

module hdr_tonemap_srgb_encode import hts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pix_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pix_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_wdata
);

  // configuration registers
  logic [23:0] exposure_r;
  logic [23:0] white_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_r <= ONE_Q816;
      white_r    <= ONE_Q816;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPOSURE: exposure_r <= cfg_wdata;
        CFG_WHITE:    white_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  hts_cfg_t cfg;
  assign cfg.gain  = exposure_r;
  assign cfg.white = (white_r == '0) ? ONE_Q816 : white_r;

  // pipeline advances unless a finished beat is held at the output
  logic en;
  logic [LAT-1:0] vld_r;

  assign en        = out_ready || !vld_r[LAT-1];
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // channel datapaths
  hts_chan u_red (
    .clk      (clk),
    .en       (en),
    .cfg      (cfg),
    .radiance (in_data.red_radiance),
    .code     (out_data.red_code)
  );

  hts_chan u_green (
    .clk      (clk),
    .en       (en),
    .cfg      (cfg),
    .radiance (in_data.green_radiance),
    .code     (out_data.green_code)
  );

  hts_chan u_blue (
    .clk      (clk),
    .en       (en),
    .cfg      (cfg),
    .radiance (in_data.blue_radiance),
    .code     (out_data.blue_code)
  );

  // checks
  `HTS_ASSERT_NEXT(a_stall_holds_line, !en, $stable(vld_r), "valid line moved during a stall")
  `HTS_ASSERT_ALWAYS(a_reset_cfg, $past(!rst_n) && rst_n, exposure_r == ONE_Q816 && white_r == ONE_Q816, "config not at reset value")
  `HTS_ASSERT_NOW(a_code_range, out_valid, (out_data.red_code >> CODE_BITS) == '0 && (out_data.green_code >> CODE_BITS) == '0 && (out_data.blue_code >> CODE_BITS) == '0, "code beyond its width")

endmodule

`default_nettype wire
